// ----- sv/cmpt_pkg.sv -----
// Shared types, constants and helpers for the color matrix pixel transform.
`timescale 1ns / 1ps
package cmpt_pkg;

  localparam int unsigned COEF_WIDTH_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 12;
  localparam int unsigned HALF_BITS          = 16;
  localparam int unsigned NUM_REGS           = 6;
  localparam int unsigned NUM_ROWS           = 3;
  localparam int unsigned REG_WIDTH          = 32;
  localparam int unsigned CFG_ADDR_W         = 3;
  localparam int unsigned PIX_W              = 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RED_RG   = 3'd0,
    REG_RED_BO   = 3'd1,
    REG_GREEN_RG = 3'd2,
    REG_GREEN_BO = 3'd3,
    REG_BLUE_RG  = 3'd4,
    REG_BLUE_BO  = 3'd5
  } cmpt_reg_e;

  // Reset image of the register file: identity matrix at Q4.12.
  localparam logic [REG_WIDTH-1:0] REG_RESET [NUM_REGS] = '{
    32'h0000_1000, 32'h0000_0000, 32'h1000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h0000_1000
  };

  // Pipeline advance strobes shared by the lanes and the merge stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } cmpt_adv_t;

  // Effective coefficient width: at most one register half.
  function automatic int unsigned eff_coef_w(input int unsigned cw);
    return (cw < HALF_BITS) ? cw : HALF_BITS;
  endfunction

  // Rounded accumulator width: room for four products plus rounding and
  // at least ten integer bits above the fraction.
  function automatic int unsigned acc_width(input int unsigned cw, input int unsigned fb);
    int unsigned a;
    int unsigned b;
    a = eff_coef_w(cw) + 11;
    b = fb + 10;
    return (a > b) ? a : b;
  endfunction

endpackage

// ----- sv/cmpt_pix_in_if.sv -----
// Input pixel channel: valid/ready handshake with an RGBA payload.
`timescale 1ns / 1ps
interface cmpt_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

// ----- sv/cmpt_pix_out_if.sv -----
// Output pixel channel: valid/ready handshake with an RGBA payload.
`timescale 1ns / 1ps
interface cmpt_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

// ----- sv/cmpt_lane.sv -----
// One matrix row: three gain products and the offset term, then their rounded sum.
`timescale 1ns / 1ps
module cmpt_lane #(
  parameter int unsigned COEF_WIDTH     = cmpt_pkg::COEF_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = cmpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  cmpt_pkg::cmpt_adv_t    adv_i,
  input  logic signed [cmpt_pkg::eff_coef_w(COEF_WIDTH)-1:0] gain_r_i,
  input  logic signed [cmpt_pkg::eff_coef_w(COEF_WIDTH)-1:0] gain_g_i,
  input  logic signed [cmpt_pkg::eff_coef_w(COEF_WIDTH)-1:0] gain_b_i,
  input  logic signed [cmpt_pkg::eff_coef_w(COEF_WIDTH)-1:0] offset_i,
  input  logic [cmpt_pkg::PIX_W-1:0] red_i,
  input  logic [cmpt_pkg::PIX_W-1:0] green_i,
  input  logic [cmpt_pkg::PIX_W-1:0] blue_i,
  output logic signed [cmpt_pkg::acc_width(COEF_WIDTH, COEF_FRAC_BITS)-1:0] rounded_o
);
  import cmpt_pkg::*;

  localparam int unsigned CW = eff_coef_w(COEF_WIDTH);
  localparam int unsigned PW = CW + PIX_W + 1;
  localparam int unsigned RW = acc_width(COEF_WIDTH, COEF_FRAC_BITS);
  localparam logic signed [RW-1:0] HALF_UNIT = RW'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0] prod_r_d, prod_r_q;
  logic signed [PW-1:0] prod_g_d, prod_g_q;
  logic signed [PW-1:0] prod_b_d, prod_b_q;
  logic signed [PW-1:0] prod_o_d, prod_o_q;
  logic signed [RW-1:0] sum_d, sum_q;

  // Pixels are unsigned: widen with a zero sign bit before the signed multiply.
  always_comb begin
    prod_r_d = PW'(gain_r_i) * PW'($signed({1'b0, red_i}));
    prod_g_d = PW'(gain_g_i) * PW'($signed({1'b0, green_i}));
    prod_b_d = PW'(gain_b_i) * PW'($signed({1'b0, blue_i}));
    // Offset is in units of full scale: times 255.
    prod_o_d = (PW'(offset_i) <<< PIX_W) - PW'(offset_i);
  end

  always_comb begin
    sum_d = RW'(prod_r_q) + RW'(prod_g_q) + RW'(prod_b_q) + RW'(prod_o_q) + HALF_UNIT;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      prod_r_q <= prod_r_d;
      prod_g_q <= prod_g_d;
      prod_b_q <= prod_b_d;
      prod_o_q <= prod_o_d;
    end
    if (adv_i.s2) begin
      sum_q <= sum_d;
    end
  end

  assign rounded_o = sum_q;

endmodule

// ----- sv/cmpt_merge.sv -----
// Output stage: scale back, clamp each lane to 0..255 and register the pixel.
`timescale 1ns / 1ps
module cmpt_merge #(
  parameter int unsigned COEF_WIDTH     = cmpt_pkg::COEF_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = cmpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  cmpt_pkg::cmpt_adv_t adv_i,
  input  logic signed [cmpt_pkg::acc_width(COEF_WIDTH, COEF_FRAC_BITS)-1:0]
                              rounded_i [cmpt_pkg::NUM_ROWS],
  input  logic [cmpt_pkg::PIX_W-1:0] alpha_i,
  output logic [cmpt_pkg::PIX_W-1:0] chan_o [cmpt_pkg::NUM_ROWS],
  output logic [cmpt_pkg::PIX_W-1:0] alpha_o
);
  import cmpt_pkg::*;

  localparam int unsigned RW = acc_width(COEF_WIDTH, COEF_FRAC_BITS);
  localparam int unsigned QW = RW - COEF_FRAC_BITS;

  logic [PIX_W-1:0] chan_d [NUM_ROWS];
  logic [PIX_W-1:0] chan_q [NUM_ROWS];
  logic [PIX_W-1:0] alpha_q;
  logic [QW-1:0]    quot   [NUM_ROWS];

  always_comb begin
    for (int i = 0; i < NUM_ROWS; i++) begin
      quot[i] = rounded_i[i][RW-1:COEF_FRAC_BITS];
      if (rounded_i[i][RW-1]) begin
        chan_d[i] = '0;
      end else if (quot[i][QW-1:PIX_W] != '0) begin
        chan_d[i] = '1;
      end else begin
        chan_d[i] = quot[i][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      chan_q  <= chan_d;
      alpha_q <= alpha_i;
    end
  end

  assign chan_o  = chan_q;
  assign alpha_o = alpha_q;

endmodule

// ----- sv/color_matrix_pixel_transform.sv -----
// Top level of the 3x4 affine color matrix applied to one RGBA pixel per beat.
//
// Usage:
//   pix_i carries one RGBA pixel per beat, pix_o returns the transformed
//   pixel, one beat out for every beat in, in order. Alpha is copied.
//   The six coefficient registers are written through cfg_we_i, cfg_addr_i
//   and cfg_wdata_i (index 0..5, writes to 6 and 7 are dropped); write them
//   only while no pixel is in flight.
// Pipeline and throughput:
//   An accepted input beat passes the product, rounded-sum and clamp registers
//   in that order before it reaches pix_o. One pixel per cycle sustained while
//   pix_o is not stalled, through the three-stage multiply/sum/clamp pipeline.
// Stalls:
//   Each stage keeps its own valid bit and moves forward when the stage after
//   it is empty or moving, so pix_i.ready stays high while any bubble is left
//   and drops only when all three stages hold a pixel and pix_o is stalled.
// Reset:
//   rst_ni clears the pipeline valid bits and loads the identity matrix into
//   the coefficient registers (truncated to the coefficient width).
`timescale 1ns / 1ps
module color_matrix_pixel_transform #(
  parameter int unsigned COEF_WIDTH     = cmpt_pkg::COEF_WIDTH_DEF,
  parameter int unsigned COEF_FRAC_BITS = cmpt_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cmpt_pix_in_if.sink                         pix_i,
  cmpt_pix_out_if.source                      pix_o,
  input  logic                                cfg_we_i,
  input  logic [cmpt_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [cmpt_pkg::REG_WIDTH-1:0]      cfg_wdata_i
);
  import cmpt_pkg::*;

  localparam int unsigned CW = eff_coef_w(COEF_WIDTH);
  localparam int unsigned RW = acc_width(COEF_WIDTH, COEF_FRAC_BITS);

  // Coefficients per row: gain red, gain green, gain blue, offset.
  logic signed [CW-1:0] gain_r_q [NUM_ROWS];
  logic signed [CW-1:0] gain_g_q [NUM_ROWS];
  logic signed [CW-1:0] gain_b_q [NUM_ROWS];
  logic signed [CW-1:0] offset_q [NUM_ROWS];

  // Register write: even index holds the red/green gains, odd the blue gain
  // and offset. Only the low CW bits of each half are kept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        gain_r_q[i] <= REG_RESET[2*i][CW-1:0];
        gain_g_q[i] <= REG_RESET[2*i][HALF_BITS+CW-1:HALF_BITS];
        gain_b_q[i] <= REG_RESET[2*i+1][CW-1:0];
        offset_q[i] <= REG_RESET[2*i+1][HALF_BITS+CW-1:HALF_BITS];
      end
    end else if (cfg_we_i) begin
      unique case (cmpt_reg_e'(cfg_addr_i))
        REG_RED_RG: begin
          gain_r_q[0] <= cfg_wdata_i[CW-1:0];
          gain_g_q[0] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        REG_RED_BO: begin
          gain_b_q[0] <= cfg_wdata_i[CW-1:0];
          offset_q[0] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        REG_GREEN_RG: begin
          gain_r_q[1] <= cfg_wdata_i[CW-1:0];
          gain_g_q[1] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        REG_GREEN_BO: begin
          gain_b_q[1] <= cfg_wdata_i[CW-1:0];
          offset_q[1] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        REG_BLUE_RG: begin
          gain_r_q[2] <= cfg_wdata_i[CW-1:0];
          gain_g_q[2] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        REG_BLUE_BO: begin
          gain_b_q[2] <= cfg_wdata_i[CW-1:0];
          offset_q[2] <= cfg_wdata_i[HALF_BITS+CW-1:HALF_BITS];
        end
        default: begin
          // Unmapped index: drop the write.
        end
      endcase
    end
  end

  // Pipeline occupancy.
  logic      v1_q, v1_d;
  logic      v2_q, v2_d;
  logic      v3_q, v3_d;
  logic      rdy1, rdy2, rdy3;
  cmpt_adv_t adv;

  always_comb begin
    rdy3   = !v3_q || pix_o.ready;
    rdy2   = !v2_q || rdy3;
    rdy1   = !v1_q || rdy2;
    adv.s1 = rdy1;
    adv.s2 = rdy2;
    adv.s3 = rdy3;
    v1_d   = rdy1 ? pix_i.valid : v1_q;
    v2_d   = rdy2 ? v1_q : v2_q;
    v3_d   = rdy3 ? v2_q : v3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign pix_i.ready = rdy1;
  assign pix_o.valid = v3_q;

  // Alpha rides alongside the first two stages.
  logic [PIX_W-1:0] alpha1_q, alpha2_q;

  always_ff @(posedge clk_i) begin
    if (adv.s1) begin
      alpha1_q <= pix_i.alpha_in;
    end
    if (adv.s2) begin
      alpha2_q <= alpha1_q;
    end
  end

  // One lane per output color channel.
  logic signed [RW-1:0] rounded [NUM_ROWS];

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    cmpt_lane #(
      .COEF_WIDTH     (COEF_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .adv_i     (adv),
      .gain_r_i  (gain_r_q[r]),
      .gain_g_i  (gain_g_q[r]),
      .gain_b_i  (gain_b_q[r]),
      .offset_i  (offset_q[r]),
      .red_i     (pix_i.red_in),
      .green_i   (pix_i.green_in),
      .blue_i    (pix_i.blue_in),
      .rounded_o (rounded[r])
    );
  end

  logic [PIX_W-1:0] chan [NUM_ROWS];
  logic [PIX_W-1:0] alpha_out;

  cmpt_merge #(
    .COEF_WIDTH     (COEF_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_merge (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .rounded_i (rounded),
    .alpha_i   (alpha2_q),
    .chan_o    (chan),
    .alpha_o   (alpha_out)
  );

  assign pix_o.red_out   = chan[0];
  assign pix_o.green_out = chan[1];
  assign pix_o.blue_out  = chan[2];
  assign pix_o.alpha_out = alpha_out;

endmodule

// ----- sv/cmpt_checker.sv -----
// Port-level checks for the color matrix pixel transform, bound to the top level.
`timescale 1ns / 1ps
module cmpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out
);

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // Hold a stalled output beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=>
      $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(alpha_out))
    else $error("output payload changed while stalled");

  // Input back-pressure only when the output side is stalled.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with a free pipeline");

  // Drain: with the output kept open and no new input beat, the pipeline empties.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ready && !in_beat) ##1 (out_ready && !in_beat) ##1 (out_ready && !in_beat)
      |=> !out_valid)
    else $error("output beat without a matching input beat");

endmodule

bind color_matrix_pixel_transform cmpt_checker u_cmpt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_i.valid),
  .in_ready  (pix_i.ready),
  .out_valid (pix_o.valid),
  .out_ready (pix_o.ready),
  .red_out   (pix_o.red_out),
  .green_out (pix_o.green_out),
  .blue_out  (pix_o.blue_out),
  .alpha_out (pix_o.alpha_out)
);
